>>> rtl/core/remapped_interrupt_mux_macros.svh
// Assertion helpers shared by the interrupt mux RTL.
`ifndef REMAPPED_INTERRUPT_MUX_MACROS_SVH
`define REMAPPED_INTERRUPT_MUX_MACROS_SVH

// Same-cycle implication under the asynchronous reset.
`define RIM_ASSERT_IMP(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
		else $error("interrupt mux check failed");

// Next-cycle implication under the asynchronous reset.
`define RIM_ASSERT_NXT(label, clk, rst_n, cond, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
		else $error("interrupt mux sequencing check failed");

`endif

>>> rtl/core/rim_pkg.sv
package rim_pkg;

	localparam int NUM_SOURCES = 32;
	localparam int SCAN_LIMIT  = (NUM_SOURCES < 32) ? NUM_SOURCES : 32;

	localparam logic [7:0] MAP_UNWIRED = 8'hff;
	localparam logic [7:0] MAP_UNGATED = 8'hfe;
	localparam logic [7:0] MAP_EN_BITS = 8'd32;

	typedef enum logic [2:0] {
		OP_LEVELS      = 3'd0,
		OP_CLEAR       = 3'd1,
		OP_WR_ENABLE   = 3'd2,
		OP_RD_STATUS   = 3'd3,
		OP_RD_ENABLE   = 3'd4,
		OP_GATE        = 3'd5,
		OP_DISPATCH    = 3'd6
	} op_t;

	typedef struct packed {
		logic [2:0]  operation;
		logic [31:0] line_levels;
		logic [31:0] write_data;
		logic [4:0]  source_index;
		logic        gate_on;
	} req_t;

	typedef struct packed {
		logic [31:0] read_data;
		logic        irq_out;
		logic [4:0]  source_number;
		logic        source_valid;
		logic        last;
	} rsp_t;

	typedef struct packed {
		logic        irq;
		logic [31:0] mask;
	} dlv_t;

	localparam logic [7:0] MAP_MISC [32] = '{
		8'hff, 8'hff, 8'hfe, 8'd3,  8'hff, 8'd5,  8'hfe, 8'hfe,
		8'd7,  8'hfe, 8'd10, 8'd11, 8'd12, 8'd6,  8'd14, 8'd15,
		8'hff, 8'hff, 8'hff, 8'd19, 8'd20, 8'd21, 8'd22, 8'd28,
		8'd24, 8'hff, 8'd26, 8'd27, 8'hff, 8'd29, 8'hff, 8'hff
	};

	localparam logic [7:0] MAP_ISO [32] = '{
		8'hff, 8'hfe, 8'd2,  8'hff, 8'hff, 8'd5,  8'hff, 8'hfe,
		8'd8,  8'hfe, 8'hff, 8'd11, 8'd12, 8'd13, 8'hff, 8'hff,
		8'hff, 8'hff, 8'hff, 8'd19, 8'd20, 8'hfe, 8'hfe, 8'hfe,
		8'hfe, 8'hff, 8'hff, 8'hff, 8'hff, 8'd29, 8'd30, 8'd31
	};

	function automatic logic [7:0] map_entry(input logic tsel, input logic [4:0] idx);
		map_entry = tsel ? MAP_ISO[idx] : MAP_MISC[idx];
	endfunction

endpackage

>>> rtl/core/remapped_interrupt_mux.sv
// Register operations are carried out in ST_EXEC and give their one result from ST_RESP.
// A new request is taken only while idle (busy low); dispatch scans the deliverable sources
// one bit per cycle in ST_SCAN, then gives its final result from ST_FLUSH.
// Results cannot be stalled: each is shown for one cycle under result_valid.
// Reset clears status, enable and table select and returns the sequencer to idle.
`include "remapped_interrupt_mux_macros.svh"

module remapped_interrupt_mux (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  rim_pkg::req_t req,
	input  logic          cfg_wr_en,
	input  logic          cfg_wr_data,
	output logic          result_valid,
	output rim_pkg::rsp_t result
);
	import rim_pkg::*;

	typedef enum logic [4:0] {
		ST_IDLE  = 5'b00001,
		ST_EXEC  = 5'b00010,
		ST_RESP  = 5'b00100,
		ST_SCAN  = 5'b01000,
		ST_FLUSH = 5'b10000
	} state_t;

	localparam logic [5:0] SCAN_LIMIT_W = 6'(SCAN_LIMIT);
	localparam logic [4:0] LAST_IDX     = 5'(SCAN_LIMIT - 1);

	state_t      state_q;
	req_t        req_q;
	logic [31:0] status_q;
	logic [31:0] enable_q;
	logic        tsel_q;
	logic [4:0]  scan_idx_q;
	logic        held_q;
	logic [4:0]  held_num_q;
	dlv_t        dlv;
	logic [7:0]  gate_entry;
	logic        accept;
	logic        hit;

	rim_deliver u_deliver (
		.tsel   (tsel_q),
		.status (status_q),
		.enable (enable_q),
		.dlv    (dlv)
	);

	assign busy       = (state_q != ST_IDLE);
	assign accept     = start && !busy;
	assign gate_entry = map_entry(tsel_q, req_q.source_index);
	assign hit        = dlv.mask[scan_idx_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q <= req;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			status_q   <= '0;
			enable_q   <= '0;
			tsel_q     <= 1'b0;
			scan_idx_q <= '0;
			held_q     <= 1'b0;
			held_num_q <= '0;
		end else begin
			if (cfg_wr_en) begin
				tsel_q <= cfg_wr_data;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= (req.operation == OP_DISPATCH) ? ST_SCAN : ST_EXEC;
						scan_idx_q <= '0;
						held_q     <= 1'b0;
					end
				end
				ST_EXEC: begin
					case (req_q.operation)
						OP_LEVELS:    status_q <= status_q | req_q.line_levels;
						OP_CLEAR:     status_q <= status_q & ~req_q.write_data;
						OP_WR_ENABLE: enable_q <= req_q.write_data;
						OP_GATE: begin
							if (({1'b0, req_q.source_index} < SCAN_LIMIT_W)
								&& (gate_entry < MAP_EN_BITS)) begin
								enable_q[gate_entry[4:0]] <= req_q.gate_on;
							end
						end
						default: ;
					endcase
					state_q <= ST_RESP;
				end
				ST_RESP: state_q <= ST_IDLE;
				ST_SCAN: begin
					// hold the latest hit so the final one can carry last
					if (hit) begin
						held_q     <= 1'b1;
						held_num_q <= scan_idx_q;
					end
					if (scan_idx_q == LAST_IDX) begin
						state_q <= ST_FLUSH;
					end else begin
						scan_idx_q <= scan_idx_q + 5'd1;
					end
				end
				ST_FLUSH: state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	always_comb begin
		result_valid         = 1'b0;
		result.read_data     = '0;
		result.irq_out       = dlv.irq;
		result.source_number = '0;
		result.source_valid  = 1'b0;
		result.last          = 1'b0;
		case (state_q)
			ST_RESP: begin
				result_valid = 1'b1;
				result.last  = 1'b1;
				if (req_q.operation == OP_RD_STATUS) begin
					result.read_data = status_q;
				end else if (req_q.operation == OP_RD_ENABLE) begin
					result.read_data = enable_q;
				end
			end
			ST_SCAN: begin
				// a new hit releases the one held before it
				if (hit && held_q) begin
					result_valid         = 1'b1;
					result.source_number = held_num_q;
					result.source_valid  = 1'b1;
				end
			end
			ST_FLUSH: begin
				result_valid         = 1'b1;
				result.last          = 1'b1;
				result.source_valid  = held_q;
				result.source_number = held_q ? held_num_q : 5'd0;
			end
			default: ;
		endcase
	end

	`RIM_ASSERT_IMP(a_result_while_busy, clk, arst_n, result_valid, busy)
	`RIM_ASSERT_NXT(a_accept_goes_busy, clk, arst_n, accept, busy)
	`RIM_ASSERT_IMP(a_source_implies_irq, clk, arst_n, result_valid && result.source_valid, result.irq_out)
	`RIM_ASSERT_NXT(a_last_frees_block, clk, arst_n, result_valid && result.last, !busy)
	`RIM_ASSERT_IMP(a_scan_state_stable, clk, arst_n, state_q == ST_SCAN && !$past(accept) && $past(state_q) == ST_SCAN, $stable(status_q) && $stable(enable_q))

endmodule

>>> rtl/core/rim_deliver.sv
module rim_deliver (
	input  logic             tsel,
	input  logic [31:0]      status,
	input  logic [31:0]      enable,
	output rim_pkg::dlv_t    dlv
);
	import rim_pkg::*;

	always_comb begin
		logic [7:0] e;
		e = '0;
		dlv.mask = '0;
		for (int i = 0; i < 32; i++) begin
			e = map_entry(tsel, 5'(i));
			dlv.mask[i] = (i < SCAN_LIMIT) && status[i] && (e != MAP_UNWIRED)
				&& !((e < MAP_EN_BITS) && !enable[e[4:0]]);
		end
		dlv.irq = |dlv.mask;
	end

endmodule

>>> verif/remapped_interrupt_mux_tb.sv
`timescale 1ns / 1ps

module remapped_interrupt_mux_tb;
	import rim_pkg::*;

	localparam int SCAN_BOUND = (NUM_SOURCES < 32) ? NUM_SOURCES : 32;
	localparam logic [2:0] OP_UNUSED = 3'd7;
	localparam logic [7:0] UNW = MAP_UNWIRED;
	localparam logic [7:0] UNG = MAP_UNGATED;

	// status bit -> enable bit, one table per table_select value
	localparam logic [0:31][7:0] MISC_ROUTE = {
		UNW,   UNW,   UNG,   8'd3,  UNW,   8'd5,  UNG,   UNG,
		8'd7,  UNG,   8'd10, 8'd11, 8'd12, 8'd6,  8'd14, 8'd15,
		UNW,   UNW,   UNW,   8'd19, 8'd20, 8'd21, 8'd22, 8'd28,
		8'd24, UNW,   8'd26, 8'd27, UNW,   8'd29, UNW,   UNW
	};
	localparam logic [0:31][7:0] ISO_ROUTE = {
		UNW,   UNG,   8'd2,  UNW,   UNW,   8'd5,  UNW,   UNG,
		8'd8,  UNG,   UNW,   8'd11, 8'd12, 8'd13, UNW,   UNW,
		UNW,   UNW,   UNW,   8'd19, 8'd20, UNG,   UNG,   UNG,
		UNG,   UNW,   UNW,   UNW,   UNW,   8'd29, 8'd30, 8'd31
	};

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	req_t req;
	logic cfg_wr_en;
	logic cfg_wr_data;
	logic result_valid;
	rsp_t result;

	// shadow copy of the mux state
	logic [31:0] status_bits;
	logic [31:0] enable_bits;
	logic        table_sel;

	rsp_t mux_outputs_due[$];
	int   errors;
	int   burst_left;

	remapped_interrupt_mux DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.req          (req),
		.cfg_wr_en    (cfg_wr_en),
		.cfg_wr_data  (cfg_wr_data),
		.result_valid (result_valid),
		.result       (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic logic [7:0] routed_enable(input logic [4:0] idx);
		routed_enable = table_sel ? ISO_ROUTE[idx] : MISC_ROUTE[idx];
	endfunction

	function automatic logic [31:0] deliverable_sources();
		logic [31:0] d;
		logic [7:0]  e;
		d = '0;
		for (int i = 0; i < SCAN_BOUND; i++) begin
			e = routed_enable(i[4:0]);
			if (status_bits[i] && e != UNW && (e == UNG || (e < 8'd32 && enable_bits[e[4:0]])))
				d[i] = 1'b1;
		end
		return d;
	endfunction

	function automatic void compute_mux_outputs(input req_t r);
		rsp_t        o;
		logic [31:0] pend;
		logic [7:0]  e;
		o = '0;
		o.last = 1'b1;
		case (r.operation)
			OP_LEVELS: status_bits = status_bits | r.line_levels;
			OP_CLEAR: status_bits = status_bits & ~r.write_data;
			OP_WR_ENABLE: enable_bits = r.write_data;
			OP_RD_STATUS: o.read_data = status_bits;
			OP_RD_ENABLE: o.read_data = enable_bits;
			OP_GATE: begin
				if (r.source_index < SCAN_BOUND) begin
					e = routed_enable(r.source_index);
					if (e < 8'd32)
						enable_bits[e[4:0]] = r.gate_on;
				end
			end
			default: ;
		endcase
		pend = deliverable_sources();
		o.irq_out = |pend;
		if (r.operation == OP_DISPATCH && pend != '0) begin
			// one transaction per deliverable source, lowest first
			for (int i = 0; i < 32; i++) begin
				if (pend[i]) begin
					pend[i] = 1'b0;
					o.source_number = i[4:0];
					o.source_valid = 1'b1;
					o.last = (pend == '0);
					mux_outputs_due.push_back(o);
				end
			end
		end else begin
			mux_outputs_due.push_back(o);
		end
	endfunction

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && result_valid) begin
			if (mux_outputs_due.size() == 0) begin
				$error("unexpected result transaction: %h", result);
				errors++;
			end else begin
				want = mux_outputs_due.pop_front();
				if (result.read_data !== want.read_data) begin
					$error("read_data: expected %h, got %h", want.read_data, result.read_data);
					errors++;
				end
				if (result.irq_out !== want.irq_out) begin
					$error("irq_out: expected %b, got %b", want.irq_out, result.irq_out);
					errors++;
				end
				if (result.source_number !== want.source_number) begin
					$error("source_number: expected %0d, got %0d",
						want.source_number, result.source_number);
					errors++;
				end
				if (result.source_valid !== want.source_valid) begin
					$error("source_valid: expected %b, got %b",
						want.source_valid, result.source_valid);
					errors++;
				end
				if (result.last !== want.last) begin
					$error("last: expected %b, got %b", want.last, result.last);
					errors++;
				end
			end
		end
	end

	function automatic req_t make_req(input logic [2:0] op, input logic [31:0] lines,
		input logic [31:0] wdata, input logic [4:0] idx, input logic on);
		req_t r;
		r.operation = op;
		r.line_levels = lines;
		r.write_data = wdata;
		r.source_index = idx;
		r.gate_on = on;
		return r;
	endfunction

	task automatic issue_request(input req_t r);
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		compute_mux_outputs(r);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			// drop start for a gap, then pick the next burst length
			start <= 1'b0;
			repeat ($urandom_range(1, 6))
				@(posedge clk);
			burst_left = $urandom_range(0, 1) ? $urandom_range(0, 4) : $urandom_range(5, 20);
		end
	endtask

	task automatic wait_until_drained();
		start <= 1'b0;
		while (mux_outputs_due.size() != 0)
			@(posedge clk);
		repeat (4)
			@(posedge clk);
		while (busy)
			@(posedge clk);
	endtask

	task automatic write_table_select(input logic value);
		wait_until_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= value;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		table_sel = value;
	endtask

	task automatic test_reset_values();
		issue_request(make_req(OP_RD_STATUS, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_RD_ENABLE, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_DISPATCH, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_UNUSED, '1, '1, '1, 1'b1));
	endtask

	task automatic test_register_extremes();
		issue_request(make_req(OP_LEVELS, 32'hffff_ffff, '0, '0, 1'b0));
		issue_request(make_req(OP_RD_STATUS, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_WR_ENABLE, '0, 32'hffff_ffff, '0, 1'b0));
		issue_request(make_req(OP_RD_ENABLE, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_DISPATCH, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_CLEAR, '0, 32'hffff_ffff, '0, 1'b0));
		issue_request(make_req(OP_RD_STATUS, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_WR_ENABLE, '0, '0, '0, 1'b0));
	endtask

	task automatic test_gating();
		issue_request(make_req(OP_LEVELS, 32'hffff_ffff, '0, '0, 1'b0));
		// remapped entries: source 13 drives enable 6, source 23 drives enable 28
		issue_request(make_req(OP_GATE, '0, '0, 5'd13, 1'b1));
		issue_request(make_req(OP_GATE, '0, '0, 5'd23, 1'b1));
		// unwired and ungated targets must leave the enable register alone
		issue_request(make_req(OP_GATE, '0, '0, 5'd0, 1'b1));
		issue_request(make_req(OP_GATE, '0, '0, 5'd2, 1'b1));
		issue_request(make_req(OP_RD_ENABLE, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_DISPATCH, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_GATE, '0, '0, 5'd13, 1'b0));
		issue_request(make_req(OP_RD_ENABLE, '0, '0, '0, 1'b0));
	endtask

	task automatic test_iso_table();
		write_table_select(1'b1);
		issue_request(make_req(OP_DISPATCH, '0, '0, '0, 1'b0));
		issue_request(make_req(OP_GATE, '0, '0, 5'd31, 1'b1));
		issue_request(make_req(OP_DISPATCH, '0, '0, '0, 1'b0));
	endtask

	task automatic test_random_traffic(input int count);
		req_t r;
		int   pick;
		for (int n = 0; n < count; n++) begin
			r = make_req(3'($urandom), $urandom, $urandom, 5'($urandom), 1'($urandom));
			pick = $urandom_range(0, 99);
			if (pick < 18) begin
				r.operation = OP_LEVELS;
				if ($urandom_range(0, 2) != 0)
					r.line_levels = $urandom & $urandom & $urandom;
			end else if (pick < 30) begin
				r.operation = OP_CLEAR;
			end else if (pick < 37) begin
				r.operation = OP_WR_ENABLE;
			end else if (pick < 45) begin
				r.operation = OP_RD_STATUS;
			end else if (pick < 52) begin
				r.operation = OP_RD_ENABLE;
			end else if (pick < 74) begin
				r.operation = OP_GATE;
			end else if (pick < 96) begin
				r.operation = OP_DISPATCH;
			end else begin
				r.operation = OP_UNUSED;
			end
			issue_request(r);
			// hold off now and then until the mux has caught up
			if ($urandom_range(0, 29) == 0)
				wait_until_drained();
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start = 1'b0;
		req = '0;
		cfg_wr_en = 1'b0;
		cfg_wr_data = 1'b0;
		status_bits = '0;
		enable_bits = '0;
		table_sel = 1'b0;
		errors = 0;
		burst_left = 0;
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_values();
		test_register_extremes();
		test_gating();
		test_iso_table();
		test_random_traffic(80);
		write_table_select(1'b0);
		test_random_traffic(70);
		write_table_select(1'b1);
		test_random_traffic(55);

		wait_until_drained();
		repeat (40)
			@(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
